### src/max_entropy_threshold_core_macros.svh
// assertion macros shared by the threshold core
`ifndef MAX_ENTROPY_THRESHOLD_CORE_MACROS_SVH
`define MAX_ENTROPY_THRESHOLD_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MET_ASSERT_SAME(lbl, ante, cons, msg)
`define MET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/met_pkg.sv
// shared types and constants of the maximum entropy threshold core
package met_pkg;

  localparam int BINS_DEF            = 256;
  localparam int MAX_PIXELS_LOG2_DEF = 20;
  localparam int PIXEL_W             = 8;
  localparam int THRESH_W            = 8;
  localparam int TOTAL_W             = 21;
  // natural log result width, Q5.24
  localparam int LN_W                = 29;
  localparam int FRAC_BITS           = 24;
  // ln 2 in Q0.32
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [TOTAL_W-1:0]  pixel_total;
  } out_beat_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic zero_wr;
    logic idx_clr;
    logic idx_inc;
    logic acc_clr;
    logic ln_go;
    logic ln_bin;
    logic div_go;
    logic side;
    logic h_ld;
    logic c_ld;
    logic mul;
    logic atot_add;
    logic part_add;
    logic best_upd;
    logic out_ld;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;
    logic ln_busy;
    logic div_busy;
    logic out_full;
  } status_t;

endpackage

### src/met_ram.sv
// generic single write port ram with registered read
module met_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [WIDTH-1:0]                      wd,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic [WIDTH-1:0]                      rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

### src/met_ln.sv
// iterative natural log unit, Q5.24 result
module met_ln #(
  parameter int XW = 21
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [XW-1:0]              x,
  output logic                       busy,
  output logic [met_pkg::LN_W-1:0]   res
);

  localparam int LW = met_pkg::LN_W;
  localparam int FB = met_pkg::FRAC_BITS;
  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_CHK  = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_FIN  = 3'd5;

  logic [2:0]     st_r;
  logic [30:0]    m_r;
  logic [4:0]     e_r;
  logic [LW-1:0]  lg_r;
  logic [4:0]     cnt_r;
  logic [61:0]    sq_r;
  logic [LW+31:0] lp_r;
  logic [LW-1:0]  res_r;
  logic [31:0]    sqh;

  assign sqh = sq_r[61:30];

  // normalize, square 24 times, scale by ln 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      unique case (st_r)
        L_IDLE: begin
          if (go) begin
            if (x == '0) begin
              res_r <= '0;
            end else begin
              m_r  <= 31'(x);
              e_r  <= 5'd30;
              st_r <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (m_r[30]) begin
            lg_r  <= LW'(e_r) << FB;
            cnt_r <= 5'(FB - 1);
            st_r  <= L_SQ;
          end else begin
            m_r <= {m_r[29:0], 1'b0};
            e_r <= e_r - 5'd1;
          end
        end
        L_SQ: begin
          sq_r <= 62'(m_r) * 62'(m_r);
          st_r <= L_CHK;
        end
        L_CHK: begin
          if (sqh[31]) begin
            m_r         <= sqh[31:1];
            lg_r[cnt_r] <= 1'b1;
          end else begin
            m_r <= sqh[30:0];
          end
          if (cnt_r == 5'd0) begin
            st_r <= L_MUL;
          end else begin
            cnt_r <= cnt_r - 5'd1;
            st_r  <= L_SQ;
          end
        end
        L_MUL: begin
          lp_r <= (LW + 32)'(lg_r) * (LW + 32)'(met_pkg::LN2_Q32);
          st_r <= L_FIN;
        end
        L_FIN: begin
          res_r <= lp_r[LW+31:32];
          st_r  <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign busy = (st_r != L_IDLE);
  assign res  = res_r;

endmodule

### src/met_div.sv
// restoring divider, one quotient bit per cycle
module met_div #(
  parameter int NW = 50,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] a,
  input  logic [DW-1:0] d,
  output logic          busy,
  output logic [NW-1:0] q
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    d_r;
  logic [DW:0]      sh;
  logic [DW:0]      diff;
  logic             ge;

  // trial subtract
  assign sh   = {rem_r, quo_r[NW-1]};
  assign ge   = (sh >= {1'b0, d_r});
  assign diff = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      quo_r  <= (d == '0) ? '0 : a;
      rem_r  <= '0;
      d_r    <= d;
      cnt_r  <= CNT_W'(NW);
      busy_r <= (d != '0);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign q    = quo_r;

endmodule

### src/met_dpath.sv
// histogram, entropy arithmetic and result register
module met_dpath #(
  parameter int BINS            = met_pkg::BINS_DEF,
  parameter int MAX_PIXELS_LOG2 = met_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  met_pkg::cmd_t                 cmd,
  output met_pkg::status_t              st,
  input  logic                          in_valid,
  input  logic [met_pkg::PIXEL_W-1:0]   in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output met_pkg::out_beat_t            out_beat
);

  localparam int BW = $clog2(BINS);
  localparam int CW = MAX_PIXELS_LOG2 + 1;
  localparam int LW = met_pkg::LN_W;
  localparam int AW = CW + LW;
  localparam logic [CW-1:0] CAP     = CW'(1) << MAX_PIXELS_LOG2;
  localparam logic [8:0]    BINS9   = 9'(BINS);
  localparam logic [BW-1:0] TOP_BIN = BW'(BINS - 1);

  logic [BW-1:0]  idx_r;
  logic [CW-1:0]  pc_r;
  logic           s1_v_r;
  logic [BW-1:0]  s1_addr_r;
  logic           w_v_r;
  logic [BW-1:0]  w_addr_r;
  logic [CW-1:0]  w_data_r;
  logic [CW-1:0]  c_r;
  logic [AW-1:0]  prod_r;
  logic [AW-1:0]  atot_r;
  logic [CW-1:0]  pt_r;
  logic [AW-1:0]  pa_r;
  logic [LW-1:0]  hl_r;
  logic [LW-1:0]  hr_r;
  logic [LW:0]    best_r;
  logic [BW-1:0]  bt_r;
  logic           out_valid_r;
  met_pkg::out_beat_t out_r;

  logic [BW-1:0]  pix_bin;
  logic           accept;
  logic           cnt_ok;
  logic [CW-1:0]  rd;
  logic [CW-1:0]  s1_base;
  logic [CW-1:0]  s1_data;
  logic           ram_we;
  logic [BW-1:0]  ram_wa;
  logic [CW-1:0]  ram_wd;
  logic [BW-1:0]  ram_ra;
  logic [CW-1:0]  side_t;
  logic [AW-1:0]  side_a;
  logic [CW-1:0]  ln_x;
  logic           ln_busy;
  logic [LW-1:0]  ln_res;
  logic           div_busy;
  logic [AW-1:0]  div_q;
  logic [LW-1:0]  h_val;
  logic [LW:0]    s_sum;

  // pixel binning, levels past the top bin fold into it
  assign pix_bin = ({1'b0, in_pixel} >= BINS9) ? TOP_BIN : in_pixel[BW-1:0];
  assign accept  = cmd.take && in_valid;
  assign cnt_ok  = (pc_r < CAP);

  // increment stage with forwarding from the previous write
  assign s1_base = (w_v_r && (w_addr_r == s1_addr_r)) ? w_data_r : rd;
  assign s1_data = s1_base + CW'(1);

  // ram port selection
  assign ram_we = s1_v_r || cmd.zero_wr;
  assign ram_wa = s1_v_r ? s1_addr_r : idx_r;
  assign ram_wd = s1_v_r ? s1_data : '0;
  assign ram_ra = cmd.take ? pix_bin : idx_r;

  met_ram #(
    .WIDTH (CW),
    .DEPTH (BINS)
  ) u_hist (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (rd)
  );

  // side operands: left is bins below t, right the rest
  assign side_t = cmd.side ? (pc_r - pt_r) : pt_r;
  assign side_a = cmd.side ? (atot_r - pa_r) : pa_r;
  assign ln_x   = cmd.ln_bin ? rd : side_t;

  met_ln #(
    .XW (CW)
  ) u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.ln_go),
    .x     (ln_x),
    .busy  (ln_busy),
    .res   (ln_res)
  );

  met_div #(
    .NW (AW),
    .DW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .a     (side_a),
    .d     (side_t),
    .busy  (div_busy),
    .q     (div_q)
  );

  // side entropy, clamped at zero
  always_comb begin
    if (side_t == '0) begin
      h_val = '0;
    end else if (div_q > AW'(ln_res)) begin
      h_val = '0;
    end else begin
      h_val = ln_res - div_q[LW-1:0];
    end
  end

  assign s_sum = {1'b0, hl_r} + {1'b0, hr_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pc_r        <= '0;
      s1_v_r      <= 1'b0;
      w_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + BW'(1);
      end
      if (cmd.out_ld) begin
        pc_r <= '0;
      end else if (accept && cnt_ok) begin
        pc_r <= pc_r + CW'(1);
      end
      s1_v_r <= accept && cnt_ok;
      w_v_r  <= s1_v_r;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_addr_r <= pix_bin;
    w_addr_r  <= s1_addr_r;
    w_data_r  <= s1_data;
    if (cmd.c_ld) begin
      c_r <= rd;
    end
    if (cmd.mul) begin
      prod_r <= AW'(c_r) * AW'(ln_res);
    end
    if (cmd.acc_clr) begin
      atot_r <= '0;
      pt_r   <= '0;
      pa_r   <= '0;
    end else begin
      if (cmd.atot_add) begin
        atot_r <= atot_r + prod_r;
      end
      if (cmd.part_add) begin
        pt_r <= pt_r + c_r;
        pa_r <= pa_r + prod_r;
      end
    end
    if (cmd.h_ld) begin
      if (cmd.side) begin
        hr_r <= h_val;
      end else begin
        hl_r <= h_val;
      end
    end
    if (cmd.best_upd) begin
      if ((idx_r == '0) || (s_sum > best_r)) begin
        best_r <= s_sum;
        bt_r   <= idx_r;
      end
    end
    if (cmd.out_ld) begin
      out_r.threshold   <= met_pkg::THRESH_W'(bt_r);
      out_r.pixel_total <= met_pkg::TOTAL_W'(pc_r);
    end
  end

  assign st.idx_last = (idx_r == TOP_BIN);
  assign st.ln_busy  = ln_busy;
  assign st.div_busy = div_busy;
  assign st.out_full = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

### src/met_ctrl.sv
// sequencer for counting, entropy passes and result hand-off
module met_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  met_pkg::status_t  st,
  output met_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FLUSH  = 4'd2;
  localparam logic [3:0] S_P1_RD  = 4'd3;
  localparam logic [3:0] S_P1_LN  = 4'd4;
  localparam logic [3:0] S_P1_LNW = 4'd5;
  localparam logic [3:0] S_P1_ACC = 4'd6;
  localparam logic [3:0] S_SW_L   = 4'd7;
  localparam logic [3:0] S_SW_LW  = 4'd8;
  localparam logic [3:0] S_SW_R   = 4'd9;
  localparam logic [3:0] S_SW_RW  = 4'd10;
  localparam logic [3:0] S_SW_CMP = 4'd11;
  localparam logic [3:0] S_SW_LN  = 4'd12;
  localparam logic [3:0] S_SW_LNW = 4'd13;
  localparam logic [3:0] S_SW_ACC = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       units_idle;

  assign units_idle = !st.ln_busy && !st.div_busy;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.zero_wr = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid && in_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.idx_clr = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_P1_RD;
      end
      S_P1_RD: begin
        state_nxt = S_P1_LN;
      end
      S_P1_LN: begin
        cmd.c_ld   = 1'b1;
        cmd.ln_go  = 1'b1;
        cmd.ln_bin = 1'b1;
        state_nxt  = S_P1_LNW;
      end
      S_P1_LNW: begin
        if (!st.ln_busy) begin
          cmd.mul   = 1'b1;
          state_nxt = S_P1_ACC;
        end
      end
      S_P1_ACC: begin
        cmd.atot_add = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SW_L;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_P1_RD;
        end
      end
      S_SW_L: begin
        cmd.ln_go  = 1'b1;
        cmd.div_go = 1'b1;
        state_nxt  = S_SW_LW;
      end
      S_SW_LW: begin
        if (units_idle) begin
          cmd.h_ld  = 1'b1;
          state_nxt = S_SW_R;
        end
      end
      S_SW_R: begin
        cmd.side   = 1'b1;
        cmd.ln_go  = 1'b1;
        cmd.div_go = 1'b1;
        state_nxt  = S_SW_RW;
      end
      S_SW_RW: begin
        cmd.side = 1'b1;
        if (units_idle) begin
          cmd.h_ld  = 1'b1;
          state_nxt = S_SW_CMP;
        end
      end
      S_SW_CMP: begin
        cmd.best_upd = 1'b1;
        state_nxt    = S_SW_LN;
      end
      S_SW_LN: begin
        cmd.c_ld    = 1'b1;
        cmd.ln_go   = 1'b1;
        cmd.ln_bin  = 1'b1;
        cmd.zero_wr = 1'b1;
        state_nxt   = S_SW_LNW;
      end
      S_SW_LNW: begin
        if (!st.ln_busy) begin
          cmd.mul   = 1'b1;
          state_nxt = S_SW_ACC;
        end
      end
      S_SW_ACC: begin
        cmd.part_add = 1'b1;
        if (st.idx_last) begin
          state_nxt = S_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SW_L;
        end
      end
      S_OUT: begin
        if (!st.out_full) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  // state register, clearing pass first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/max_entropy_threshold_core.sv
// maximum entropy gray threshold core, top level
//
// channel  direction  handshake            beat
// in       input      in_valid / in_stall  met_pkg::in_beat_t  {pixel, last_pixel}
// out      output     out_valid/out_stall  met_pkg::out_beat_t {threshold, pixel_total}
//
// pixels are taken one per cycle, while in_stall is low, into the histogram ram
// (read, increment, write back). after the last pixel: a flush step, a pass summing c*ln(c),
// then a sweep; each bin waits on the log unit (normalize shifts plus 24 squaring steps),
// and in the sweep the divider runs beside it.
// after reset a clearing pass holds in_stall high; the sweep clears bins.
// a stalled result sits in the output register while the next image is counted.
`include "max_entropy_threshold_core_macros.svh"
module max_entropy_threshold_core #(
  parameter int BINS            = met_pkg::BINS_DEF,
  parameter int MAX_PIXELS_LOG2 = met_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  met_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output met_pkg::out_beat_t out_beat
);

  met_pkg::cmd_t    cmd;
  met_pkg::status_t st;
  logic             last_taken;

  assign in_stall = !cmd.take;

  // last pixel beat taken
  assign last_taken = in_valid && !in_stall && in_beat.last_pixel;

  // sequencer
  met_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_beat.last_pixel),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  met_dpath #(
    .BINS            (BINS),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_valid  (in_valid),
    .in_pixel  (in_beat.pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // checks on sequencing
  `MET_ASSERT_NEXT(a_last_stalls, last_taken, in_stall, "input open after last pixel")
  `MET_ASSERT_SAME(a_ln_free, cmd.ln_go, !st.ln_busy, "log unit started while busy")
  `MET_ASSERT_SAME(a_div_free, cmd.div_go, !st.div_busy, "divider started while busy")
  `MET_ASSERT_SAME(a_out_free, cmd.out_ld, !st.out_full, "result loaded over a held beat")

endmodule

### tb/max_entropy_threshold_checker.sv
// checker for the threshold core: histogram predictor and result scoreboard
module max_entropy_threshold_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  met_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  met_pkg::out_beat_t out_beat,
  output int                 fail_count,
  output int                 pending
);

  localparam int HIST_BINS = met_pkg::BINS_DEF;
  localparam logic [63:0] COUNT_CAP = 64'd1 << met_pkg::MAX_PIXELS_LOG2_DEF;

  logic [met_pkg::TOTAL_W-1:0] hist [HIST_BINS];
  logic [63:0]                 pixels_seen;
  met_pkg::out_beat_t          expected_thresholds [$];

  // natural log in Q40.24 by repeated squaring of the normalized mantissa
  function automatic logic [63:0] ln_fixed(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] lg;
    int n;
    if (x == 0) return 0;
    n = 0;
    while (n < 40 && (x >> (n + 1)) != 0) n++;
    if (n > 30) y = x >> (n - 30);
    else y = x << (30 - n);
    lg = 64'(n) << met_pkg::FRAC_BITS;
    for (int k = met_pkg::FRAC_BITS - 1; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        lg[k] = 1'b1;
      end
    end
    return (lg * 64'(met_pkg::LN2_Q32)) >> 32;
  endfunction

  // entropy of one side from its pixel total and its sum of c*ln(c)
  function automatic logic [63:0] side_entropy(input logic [63:0] total,
                                               input logic [63:0] weighted);
    logic [63:0] lt;
    logic [63:0] q;
    if (total == 0) return 0;
    lt = ln_fixed(total);
    q = weighted / total;
    return (q > lt) ? 64'd0 : lt - q;
  endfunction

  // sweep every threshold, first maximum of the summed entropy wins
  function automatic logic [met_pkg::THRESH_W-1:0] best_threshold();
    logic [63:0] all_tot, all_acc, lo_tot, lo_acc, s, best;
    logic [63:0] wt [HIST_BINS];
    logic        found;
    logic [met_pkg::THRESH_W-1:0] best_t;
    all_tot = 0;
    all_acc = 0;
    for (int i = 0; i < HIST_BINS; i++) begin
      wt[i] = 64'(hist[i]) * ln_fixed(64'(hist[i]));
      all_tot += 64'(hist[i]);
      all_acc += wt[i];
    end
    lo_tot = 0;
    lo_acc = 0;
    found = 1'b0;
    best = 0;
    best_t = '0;
    for (int t = 0; t < HIST_BINS; t++) begin
      s = side_entropy(lo_tot, lo_acc) +
          side_entropy(all_tot - lo_tot, all_acc - lo_acc);
      if (!found || s > best) begin
        found = 1'b1;
        best = s;
        best_t = met_pkg::THRESH_W'(t);
      end
      lo_tot += 64'(hist[t]);
      lo_acc += wt[t];
    end
    return best_t;
  endfunction

  assign pending = expected_thresholds.size();

  // count accepted pixels and predict on the last one
  always @(posedge clk) begin
    met_pkg::out_beat_t exp_beat;
    if (!rst_n) begin
      for (int i = 0; i < HIST_BINS; i++) hist[i] = '0;
      pixels_seen = 0;
    end else if (in_valid && !in_stall) begin
      if (pixels_seen < COUNT_CAP) begin
        hist[in_beat.pixel] = hist[in_beat.pixel] + met_pkg::TOTAL_W'(1);
        pixels_seen++;
      end
      if (in_beat.last_pixel) begin
        exp_beat.threshold = best_threshold();
        exp_beat.pixel_total = met_pkg::TOTAL_W'(pixels_seen);
        expected_thresholds.push_back(exp_beat);
        for (int i = 0; i < HIST_BINS; i++) hist[i] = '0;
        pixels_seen = 0;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    met_pkg::out_beat_t exp_beat;
    if (!rst_n) begin
      fail_count = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_thresholds.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: threshold %0d total %0d",
                   out_beat.threshold, out_beat.pixel_total);
      end else begin
        exp_beat = expected_thresholds.pop_front();
        if (out_beat.threshold !== exp_beat.threshold ||
            out_beat.pixel_total !== exp_beat.pixel_total) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch: threshold exp %0d got %0d, total exp %0d got %0d",
                     exp_beat.threshold, out_beat.threshold,
                     exp_beat.pixel_total, out_beat.pixel_total);
        end
      end
    end
  end
endmodule

### tb/tb_max_entropy_threshold_core.sv
// testbench top for the threshold core: pixel stimulus, result stalls and verdict
module tb_max_entropy_threshold_core;

  localparam int IDLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  met_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_stall;
  met_pkg::out_beat_t out_beat;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  int                 stall_mode;

  max_entropy_threshold_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  max_entropy_threshold_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // short gaps mostly, a long one now and then
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one pixel beat and hold it until taken
  task automatic send_pixel(input logic [met_pkg::PIXEL_W-1:0] pix, input logic last);
    int g;
    in_valid <= 1'b1;
    in_beat.pixel <= pix;
    in_beat.last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one image of random content in a chosen style
  task automatic send_image(input int npix, input int style);
    logic [met_pkg::PIXEL_W-1:0] pix, base, other;
    base = met_pkg::PIXEL_W'($urandom_range(0, 255));
    other = met_pkg::PIXEL_W'($urandom_range(0, 255));
    for (int i = 0; i < npix; i++) begin
      case (style)
        0: pix = met_pkg::PIXEL_W'($urandom_range(0, 255));
        1: pix = ($urandom_range(0, 1) ? base : other) ^
                 met_pkg::PIXEL_W'($urandom_range(0, 7));
        2: pix = base + met_pkg::PIXEL_W'($urandom_range(0, 15));
        3: pix = base;
        default: pix = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      endcase
      send_pixel(pix, i == npix - 1);
    end
  endtask

  // result side stall pattern, changing in stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 19) != 0);
      endcase
    end
  end

  // watchdog on cycles with no accepted beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int npix;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single pixel images at the gray extremes
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    // two pixels, both extremes
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    // constant image and alternating bit patterns
    for (int i = 0; i < 5; i++) send_pixel(8'd128, i == 4);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h0F, 1'b0);
    send_pixel(8'hF0, 1'b1);

    // hold off until all predictions have drained
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    // random images, mostly small
    for (int img = 0; img < 39; img++) begin
      npix = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                         : $urandom_range(1, 60);
      send_image(npix, $urandom_range(0, 4));
      if (img == 19) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
